### src/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_e;

  typedef struct packed {
    logic valid;
    logic gray;
  } rhc_ctl_t;

endpackage

### src/rhc_if.sv
`timescale 1ns / 1ps

interface rhc_pix_if #(
  parameter int unsigned CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic [CHANNEL_BITS-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rhc_hsl_if #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS-1:0] hue;
  logic [FRACTION_BITS-1:0] saturation;
  logic [FRACTION_BITS-1:0] lightness;
  logic [CHANNEL_BITS-1:0]  alpha_out;

  modport source (output valid, hue, saturation, lightness, alpha_out, input ready);
  modport sink   (input valid, hue, saturation, lightness, alpha_out, output ready);
endinterface

### src/rhc_front.sv
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned SNumBits = CHANNEL_BITS + FRACTION_BITS + 1,
  localparam int unsigned HDenBits = CHANNEL_BITS + 3,
  localparam int unsigned HNumBits = CHANNEL_BITS + FRACTION_BITS + 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  input  logic [CHANNEL_BITS-1:0] alpha_i,
  output rhc_ctl_t                ctl_o,
  output logic [CHANNEL_BITS-1:0] alpha_o,
  output logic [CHANNEL_BITS:0]   l_sum_o,
  output logic [SNumBits-1:0]     s_num_o,
  output logic [CHANNEL_BITS-1:0] s_den_o,
  output logic [HNumBits-1:0]     h_num_o,
  output logic [HDenBits-1:0]     h_den_o
);

  localparam logic [CHANNEL_BITS:0] CMax    = {1'b0, {CHANNEL_BITS{1'b1}}};
  localparam logic [CHANNEL_BITS:0] TwoCMax = {{CHANNEL_BITS{1'b1}}, 1'b0};

  // stage A: extremes and hue sector
  logic [CHANNEL_BITS-1:0] hi_d, lo_d, hi_rg, lo_rg;
  rhc_sector_e             sec_d;

  logic                    a_vld_q;
  logic [CHANNEL_BITS-1:0] a_red_q, a_green_q, a_blue_q, a_alpha_q, a_hi_q, a_lo_q;
  rhc_sector_e             a_sec_q;

  always_comb begin
    hi_rg = (red_i > green_i) ? red_i : green_i;
    lo_rg = (red_i < green_i) ? red_i : green_i;
    hi_d  = (blue_i > hi_rg) ? blue_i : hi_rg;
    lo_d  = (blue_i < lo_rg) ? blue_i : lo_rg;
    if (hi_d == red_i) begin
      sec_d = SEC_RED;
    end else if (hi_d == green_i) begin
      sec_d = SEC_GREEN;
    end else begin
      sec_d = SEC_BLUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_red_q   <= red_i;
      a_green_q <= green_i;
      a_blue_q  <= blue_i;
      a_alpha_q <= alpha_i;
      a_hi_q    <= hi_d;
      a_lo_q    <= lo_d;
      a_sec_q   <= sec_d;
    end
  end

  // stage B: divider operands
  logic [CHANNEL_BITS:0]   sum;
  logic [CHANNEL_BITS-1:0] diff, den_d;
  logic [HDenBits-1:0]     sixd, num, r_x, g_x, b_x;

  always_comb begin
    sum   = {1'b0, a_hi_q} + {1'b0, a_lo_q};
    diff  = a_hi_q - a_lo_q;
    den_d = (sum > CMax) ? CHANNEL_BITS'(TwoCMax - sum) : sum[CHANNEL_BITS-1:0];
    sixd  = {1'b0, diff, 2'b00} + {2'b00, diff, 1'b0};
    r_x   = {3'b000, a_red_q};
    g_x   = {3'b000, a_green_q};
    b_x   = {3'b000, a_blue_q};
    unique case (a_sec_q)
      SEC_RED:   num = (a_green_q >= a_blue_q) ? (g_x - b_x) : (sixd - (b_x - g_x));
      SEC_GREEN: num = {2'b00, diff, 1'b0} + b_x - r_x;
      SEC_BLUE:  num = {1'b0, diff, 2'b00} + r_x - g_x;
      default:   num = '0;
    endcase
  end

  logic b_vld_q, b_gray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_gray_q <= (a_hi_q == a_lo_q);
      alpha_o  <= a_alpha_q;
      l_sum_o  <= sum;
      s_num_o  <= {1'b0, diff, {FRACTION_BITS{1'b0}}};
      s_den_o  <= den_d;
      h_num_o  <= {1'b0, num, {FRACTION_BITS{1'b0}}};
      h_den_o  <= sixd;
    end
  end

  assign ctl_o = '{valid: b_vld_q, gray: b_gray_q};

endmodule

### src/rhc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. The quotient must fit QUO_BITS.
module rhc_div #(
  parameter int unsigned DEN_BITS = 9,
  parameter int unsigned QUO_BITS = 17
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [QUO_BITS+DEN_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0]          den_i,
  output logic [QUO_BITS-1:0]          quo_o
);

  logic [DEN_BITS-1:0] rem_q [QUO_BITS];
  logic [DEN_BITS-1:0] den_q [QUO_BITS];
  logic [QUO_BITS-1:0] low_q [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [DEN_BITS-1:0] rem_in, den_in;
    logic [QUO_BITS-1:0] low_in, quo_in;
    logic [DEN_BITS:0]   trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i[QUO_BITS+DEN_BITS-1:QUO_BITS];
      assign low_in = num_i[QUO_BITS-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_BITS-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
        low_q[k] <= {low_in[QUO_BITS-2:0], 1'b0};
        quo_q[k] <= {quo_in[QUO_BITS-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_BITS-1];

endmodule

### src/rgb_to_hsl_converter_unit.sv
`timescale 1ns / 1ps

// RGBA to HSL converter. Takes one pixel per clock while the output is not
// stalled and returns one HSL beat per pixel, in order. A pixel passes two
// stages of min/max and operand setup, FRACTION_BITS + 1 stages in the two
// parallel bit-per-stage dividers (saturation, hue), then one output register,
// so up to FRACTION_BITS + 4 pixels are in flight. Lightness is a multiply of
// the channel sum by a constant reciprocal and is delayed alongside the
// dividers. The whole pipeline advances whenever the output register is empty
// or being taken, so pix_i.ready follows hsl_o.ready and throughput is one
// pixel per cycle while the sink keeps up. Gray pixels give hue and saturation
// 0; saturation clips at all ones; alpha is copied through.
module rgb_to_hsl_converter_unit import rhc_pkg::*; #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsl_if.source hsl_o
);

  localparam int unsigned QuoBits  = FRACTION_BITS + 1;
  localparam int unsigned SumBits  = CHANNEL_BITS + 1;
  localparam int unsigned HDenBits = CHANNEL_BITS + 3;
  localparam int unsigned RecShift = 2 * CHANNEL_BITS + 2;
  localparam int unsigned RecBits  = CHANNEL_BITS + FRACTION_BITS + 2;
  localparam longint unsigned LDen   = 2 * ((64'd1 << CHANNEL_BITS) - 1);
  localparam longint unsigned LScale = (64'd1 << FRACTION_BITS) - 1;
  // ceil(2^RecShift * LScale / LDen), exact floor for every channel sum
  localparam logic [RecBits-1:0] LRecip =
    RecBits'(((LScale << RecShift) + LDen - 1) / LDen);

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || hsl_o.ready;
  assign pix_i.ready = en;

  rhc_ctl_t                                   ctl;
  logic [CHANNEL_BITS-1:0]                    f_alpha;
  logic [SumBits-1:0]                         l_sum;
  logic [QuoBits+CHANNEL_BITS-1:0]            s_num;
  logic [CHANNEL_BITS-1:0]                    s_den;
  logic [QuoBits+HDenBits-1:0]                h_num;
  logic [HDenBits-1:0]                        h_den;
  logic [QuoBits-1:0]                         s_quo, h_quo;

  rhc_front #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pix_i.valid),
    .red_i  (pix_i.red),
    .green_i(pix_i.green),
    .blue_i (pix_i.blue),
    .alpha_i(pix_i.alpha),
    .ctl_o  (ctl),
    .alpha_o(f_alpha),
    .l_sum_o(l_sum),
    .s_num_o(s_num),
    .s_den_o(s_den),
    .h_num_o(h_num),
    .h_den_o(h_den)
  );

  rhc_div #(.DEN_BITS(CHANNEL_BITS), .QUO_BITS(QuoBits)) u_div_s (
    .clk_i(clk_i), .en_i(en), .num_i(s_num), .den_i(s_den), .quo_o(s_quo)
  );

  rhc_div #(.DEN_BITS(HDenBits), .QUO_BITS(QuoBits)) u_div_h (
    .clk_i(clk_i), .en_i(en), .num_i(h_num), .den_i(h_den), .quo_o(h_quo)
  );

  // lightness: sum * LRecip >> RecShift
  logic [SumBits+RecBits-1:0] l_prod;

  assign l_prod = {{RecBits{1'b0}}, l_sum} * {{SumBits{1'b0}}, LRecip};

  // sideband alongside the dividers
  logic [QuoBits-1:0]       dly_vld_q, dly_gray_q;
  logic [CHANNEL_BITS-1:0]  dly_alpha_q [QuoBits];
  logic [FRACTION_BITS-1:0] dly_light_q [QuoBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
    end else if (en) begin
      dly_vld_q <= {dly_vld_q[QuoBits-2:0], ctl.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_gray_q     <= {dly_gray_q[QuoBits-2:0], ctl.gray};
      dly_alpha_q[0] <= f_alpha;
      dly_light_q[0] <= l_prod[RecShift +: FRACTION_BITS];
      for (int k = 1; k < QuoBits; k++) begin
        dly_alpha_q[k] <= dly_alpha_q[k-1];
        dly_light_q[k] <= dly_light_q[k-1];
      end
    end
  end

  // output register
  logic                     gray;
  logic [FRACTION_BITS-1:0] hue_d, sat_d;
  logic [FRACTION_BITS-1:0] hue_q, sat_q, light_q;
  logic [CHANNEL_BITS-1:0]  alpha_q;

  always_comb begin
    gray  = dly_gray_q[QuoBits-1];
    hue_d = gray ? '0 : h_quo[FRACTION_BITS-1:0];
    if (gray) begin
      sat_d = '0;
    end else if (s_quo[FRACTION_BITS]) begin
      sat_d = '1;
    end else begin
      sat_d = s_quo[FRACTION_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dly_vld_q[QuoBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= dly_light_q[QuoBits-1];
      alpha_q <= dly_alpha_q[QuoBits-1];
    end
  end

  assign hsl_o.valid      = out_vld_q;
  assign hsl_o.hue        = hue_q;
  assign hsl_o.saturation = sat_q;
  assign hsl_o.lightness  = light_q;
  assign hsl_o.alpha_out  = alpha_q;

endmodule

### src/rhc_checker.sv
`timescale 1ns / 1ps

module rhc_checker #(
  parameter int unsigned CHANNEL_BITS  = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [FRACTION_BITS-1:0] hue_i,
  input logic [FRACTION_BITS-1:0] saturation_i,
  input logic [FRACTION_BITS-1:0] lightness_i,
  input logic [CHANNEL_BITS-1:0]  alpha_out_i
);

  localparam int unsigned Depth   = FRACTION_BITS + 4;
  localparam int unsigned CntBits = $clog2(Depth + 2);
  localparam logic [CntBits-1:0] DepthCnt = CntBits'(Depth);

  logic               in_acc, out_acc;
  logic [CntBits-1:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // pixels taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without an accepted pixel");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("more pixels in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hue_i) &&
    $stable(saturation_i) && $stable(lightness_i) && $stable(alpha_out_i))
    else $error("stalled result beat changed");

endmodule

bind rgb_to_hsl_converter_unit rhc_checker #(
  .CHANNEL_BITS (CHANNEL_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_rhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hsl_o.valid),
  .out_ready_i (hsl_o.ready),
  .hue_i       (hsl_o.hue),
  .saturation_i(hsl_o.saturation),
  .lightness_i (hsl_o.lightness),
  .alpha_out_i (hsl_o.alpha_out)
);
